/* rtl/core/frt_pkg.sv */
package frt_pkg;

    // Table and buffer geometry.
    localparam int SLOTS        = 4;
    localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BUFFER_BYTES = 65536;

    // Field widths fixed by the port list.
    localparam int ID_W        = 32;
    localparam int COORD_W     = 32;
    localparam int SIZE_W      = 32;
    localparam int DELTA_W     = 16;
    localparam int CFG_W       = 20;
    localparam int TIME_W      = 32;
    localparam int LEN_W       = 17;
    localparam int SLOT_OUT_W  = 2;
    localparam int MODE_W      = 2;

    // Timeout register value after reset, in milliseconds.
    localparam logic [CFG_W-1:0] TIMEOUT_RESET = CFG_W'(5000);

    // Most timeout events one tick may report.
    localparam int MAX_RES = 4;
    localparam int CNT_W   = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;

    // Item kinds on the mode field.
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HEADER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DATA   = 2'd2;

    // Event codes on the result channel.
    typedef enum logic [1:0] {
        EV_DONE    = 2'd0,
        EV_TIMEOUT = 2'd1,
        EV_RANGE   = 2'd2,
        EV_FULL    = 2'd3
    } event_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   capture;
        logic   apply;
        logic   eval;
        logic   out_load;
        event_t out_kind;
        logic   out_last;
        logic   clear_cur;
        logic   pop;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic range_err;
        logic no_slot;
        logic done_ready;
        logic stale_any;
        logic stale_one;
    } sts_t;

endpackage

/* rtl/core/fragment_reassembly_tracker.sv */
// Fragment reassembly tracker: follows up to four fragmented transfers by id.
// Input channel (in_valid/in_stall) carries one item per transfer: a tick
// (mode 0) with elapsed milliseconds, a header (mode 1) with flag, target
// coordinates and total size, or a data fragment (mode 2) with offset and length.
// Mode 3 items are taken and ignored. Result channel
// (out_valid/out_stall) carries events: completion, timeout, offset out of
// range, or table full; last marks the final event caused by one input item.
// A header or fragment goes from its transfer through slot lookup and update,
// then the completion check, and back to idle; a dropped item goes back to
// idle from the lookup. Its event is loaded in the last of these steps and can
// transfer in the next cycle. An event waits in the output register if the
// receiver stalls, and lookup, check or sweep holds until that register frees up.
// A tick goes through the timeout compare and then a sweep that reports one
// event per timed-out slot, up to four events; the stale slots are found in one
// parallel compare and then reported lowest first.
// in_stall is high whenever an item is in progress, so a new item is taken only
// once the last one is through. The output register lets a new item enter while
// the last event is still waiting to be taken. Reset clears the slot table, the
// clock and the output valid, and loads the timeout register with 5000 ms. The
// user must write the timeout register through cfg_valid/cfg_ready only while
// the block is idle; the block does not enforce this. cfg_ready is always high.
module fragment_reassembly_tracker (
    input  logic                               clk,
    input  logic                               rst_n,
    // Item input.
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [frt_pkg::MODE_W-1:0]         mode,
    input  logic [frt_pkg::ID_W-1:0]           transmission_id,
    input  logic                               compressed_flag,
    input  logic signed [frt_pkg::COORD_W-1:0] coord_x,
    input  logic signed [frt_pkg::COORD_W-1:0] coord_y,
    input  logic signed [frt_pkg::COORD_W-1:0] coord_z,
    input  logic [frt_pkg::SIZE_W-1:0]         total_size,
    input  logic [frt_pkg::SIZE_W-1:0]         data_offset,
    input  logic [frt_pkg::SIZE_W-1:0]         data_length,
    input  logic [frt_pkg::DELTA_W-1:0]        delta_ms,
    // Timeout register write.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [frt_pkg::CFG_W-1:0]          cfg_data,
    // Event output.
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         event_res,
    output logic [frt_pkg::SLOT_OUT_W-1:0]     slot,
    output logic [frt_pkg::ID_W-1:0]           event_id,
    output logic                               is_compressed,
    output logic signed [frt_pkg::COORD_W-1:0] target_x,
    output logic signed [frt_pkg::COORD_W-1:0] target_y,
    output logic signed [frt_pkg::COORD_W-1:0] target_z,
    output logic [frt_pkg::LEN_W-1:0]          payload_length,
    output logic                               last
);

    frt_pkg::cmd_t cmd;
    frt_pkg::sts_t sts;

    // The register may be written at any time the block is idle, so the
    // write channel never pushes back.
    assign cfg_ready = 1'b1;

    // The controller sequences each item; all slot state and the output
    // register live in the datapath.
    frt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_mode  (mode),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    frt_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .mode            (mode),
        .transmission_id (transmission_id),
        .compressed_flag (compressed_flag),
        .coord_x         (coord_x),
        .coord_y         (coord_y),
        .coord_z         (coord_z),
        .total_size      (total_size),
        .data_offset     (data_offset),
        .data_length     (data_length),
        .delta_ms        (delta_ms),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .sts             (sts),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .event_res       (event_res),
        .slot            (slot),
        .event_id        (event_id),
        .is_compressed   (is_compressed),
        .target_x        (target_x),
        .target_y        (target_y),
        .target_z        (target_z),
        .payload_length  (payload_length),
        .last            (last)
    );

endmodule

/* rtl/core/frt_ctrl.sv */
module frt_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [frt_pkg::MODE_W-1:0] in_mode,
    output logic                       in_stall,
    output frt_pkg::cmd_t              cmd,
    input  frt_pkg::sts_t              sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_CHECK,
        S_EVAL,
        S_SWEEP
    } state_t;

    state_t                     state_reg, state_next;
    logic [frt_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       pop_last;

    assign in_stall = (state_reg != S_IDLE);
    assign pop_last = sts.stale_one || (cnt_reg == frt_pkg::CNT_W'(frt_pkg::MAX_RES - 1));

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (in_mode)
                        frt_pkg::MODE_TICK:   state_next = S_EVAL;
                        frt_pkg::MODE_HEADER: state_next = S_LOOKUP;
                        frt_pkg::MODE_DATA:   state_next = S_LOOKUP;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_LOOKUP:
            begin
                if (sts.range_err || sts.no_slot)
                begin
                    if (sts.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = sts.range_err ? frt_pkg::EV_RANGE : frt_pkg::EV_FULL;
                        cmd.out_last = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!sts.done_ready)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_kind  = frt_pkg::EV_DONE;
                    cmd.out_last  = 1'b1;
                    cmd.clear_cur = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                cnt_next   = '0;
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                if (!sts.stale_any)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.pop      = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_kind = frt_pkg::EV_TIMEOUT;
                    cmd.out_last = pop_last;
                    cnt_next     = cnt_reg + 1'b1;
                    if (pop_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* rtl/core/frt_dpath.sv */
module frt_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [frt_pkg::MODE_W-1:0]         mode,
    input  logic [frt_pkg::ID_W-1:0]           transmission_id,
    input  logic                               compressed_flag,
    input  logic signed [frt_pkg::COORD_W-1:0] coord_x,
    input  logic signed [frt_pkg::COORD_W-1:0] coord_y,
    input  logic signed [frt_pkg::COORD_W-1:0] coord_z,
    input  logic [frt_pkg::SIZE_W-1:0]         total_size,
    input  logic [frt_pkg::SIZE_W-1:0]         data_offset,
    input  logic [frt_pkg::SIZE_W-1:0]         data_length,
    input  logic [frt_pkg::DELTA_W-1:0]        delta_ms,
    input  logic                               cfg_we,
    input  logic [frt_pkg::CFG_W-1:0]          cfg_data,
    input  frt_pkg::cmd_t                      cmd,
    output frt_pkg::sts_t                      sts,
    input  logic                               out_stall,
    output logic                               out_valid,
    output logic [1:0]                         event_res,
    output logic [frt_pkg::SLOT_OUT_W-1:0]     slot,
    output logic [frt_pkg::ID_W-1:0]           event_id,
    output logic                               is_compressed,
    output logic signed [frt_pkg::COORD_W-1:0] target_x,
    output logic signed [frt_pkg::COORD_W-1:0] target_y,
    output logic signed [frt_pkg::COORD_W-1:0] target_z,
    output logic [frt_pkg::LEN_W-1:0]          payload_length,
    output logic                               last
);

    localparam int N  = frt_pkg::SLOTS;
    localparam int SW = frt_pkg::SLOT_W;

    function automatic logic [SW-1:0] lowest_idx(input logic [N-1:0] v);
        logic [SW-1:0] r;
        r = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = SW'(i);
            end
        end
        return r;
    endfunction

    // Configuration and time base.
    logic [frt_pkg::CFG_W-1:0]  timeout_reg;
    logic [frt_pkg::TIME_W-1:0] elapsed_reg;

    // Captured item.
    logic                               is_hdr_reg;
    logic                               range_reg;
    logic [frt_pkg::ID_W-1:0]           id_reg;
    logic                               comp_reg;
    logic signed [frt_pkg::COORD_W-1:0] x_reg, y_reg, z_reg;
    logic [frt_pkg::SIZE_W-1:0]         total_reg;
    logic [frt_pkg::SIZE_W-1:0]         len_reg;
    logic [frt_pkg::SIZE_W-1:0]         room_reg;

    // Slot table.
    logic [N-1:0]                       active_reg, seen_reg, stale_reg;
    logic [frt_pkg::ID_W-1:0]           ident_reg    [N];
    logic                               comp_bit_reg [N];
    logic signed [frt_pkg::COORD_W-1:0] pos_x_reg    [N];
    logic signed [frt_pkg::COORD_W-1:0] pos_y_reg    [N];
    logic signed [frt_pkg::COORD_W-1:0] pos_z_reg    [N];
    logic [frt_pkg::SIZE_W-1:0]         expected_reg [N];
    logic [frt_pkg::SIZE_W-1:0]         received_reg [N];
    logic [frt_pkg::TIME_W-1:0]         touched_reg  [N];
    logic [SW-1:0]                      cur_reg;

    logic                               out_valid_reg;

    logic [N-1:0]                       match, free, stale_next;
    logic                               hit;
    logic [SW-1:0]                      sel_idx, pop_idx, rd_idx;
    logic [frt_pkg::SIZE_W-1:0]         clip_len, base_rx;
    logic [frt_pkg::LEN_W-1:0]          clip_total;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            match[i]      = active_reg[i] && (ident_reg[i] == id_reg);
            free[i]       = !active_reg[i];
            stale_next[i] = active_reg[i] &&
                            ((elapsed_reg - touched_reg[i]) > frt_pkg::TIME_W'(timeout_reg));
        end
    end

    assign hit      = |match;
    assign sel_idx  = hit ? lowest_idx(match) : lowest_idx(free);
    assign pop_idx  = lowest_idx(stale_reg);
    assign rd_idx   = cmd.pop ? pop_idx : cur_reg;
    assign clip_len = (len_reg > room_reg) ? room_reg : len_reg;
    assign base_rx  = hit ? received_reg[sel_idx] : '0;

    assign clip_total = (expected_reg[rd_idx] > frt_pkg::SIZE_W'(frt_pkg::BUFFER_BYTES)) ?
                        frt_pkg::LEN_W'(frt_pkg::BUFFER_BYTES) :
                        frt_pkg::LEN_W'(expected_reg[rd_idx]);

    assign sts.out_free   = !out_valid_reg || !out_stall;
    assign sts.range_err  = range_reg;
    assign sts.no_slot    = !hit && !(|free);
    assign sts.done_ready = seen_reg[cur_reg] && (received_reg[cur_reg] == expected_reg[cur_reg]);
    assign sts.stale_any  = |stale_reg;
    assign sts.stale_one  = ((stale_reg & (stale_reg - 1'b1)) == '0);

    assign out_valid = out_valid_reg;

    // Control state and time base.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= frt_pkg::TIMEOUT_RESET;
            elapsed_reg   <= '0;
            active_reg    <= '0;
            seen_reg      <= '0;
            stale_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_data;
            end
            if (cmd.capture && (mode == frt_pkg::MODE_TICK))
            begin
                elapsed_reg <= elapsed_reg + frt_pkg::TIME_W'(delta_ms);
            end
            if (cmd.apply)
            begin
                active_reg[sel_idx] <= 1'b1;
                if (is_hdr_reg)
                begin
                    seen_reg[sel_idx] <= 1'b1;
                end
            end
            if (cmd.clear_cur)
            begin
                active_reg[cur_reg] <= 1'b0;
                seen_reg[cur_reg]   <= 1'b0;
            end
            if (cmd.eval)
            begin
                stale_reg <= stale_next;
            end
            if (cmd.pop)
            begin
                active_reg[pop_idx] <= 1'b0;
                seen_reg[pop_idx]   <= 1'b0;
                stale_reg[pop_idx]  <= 1'b0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item capture and slot contents.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            is_hdr_reg <= (mode == frt_pkg::MODE_HEADER);
            range_reg  <= (mode == frt_pkg::MODE_DATA) &&
                          (data_offset >= frt_pkg::SIZE_W'(frt_pkg::BUFFER_BYTES));
            id_reg     <= transmission_id;
            comp_reg   <= compressed_flag;
            x_reg      <= coord_x;
            y_reg      <= coord_y;
            z_reg      <= coord_z;
            total_reg  <= total_size;
            len_reg    <= data_length;
            room_reg   <= frt_pkg::SIZE_W'(frt_pkg::BUFFER_BYTES) - data_offset;
        end
        if (cmd.apply)
        begin
            cur_reg              <= sel_idx;
            touched_reg[sel_idx] <= elapsed_reg;
            if (!hit)
            begin
                ident_reg[sel_idx] <= id_reg;
            end
            if (is_hdr_reg)
            begin
                comp_bit_reg[sel_idx] <= comp_reg;
                pos_x_reg[sel_idx]    <= x_reg;
                pos_y_reg[sel_idx]    <= y_reg;
                pos_z_reg[sel_idx]    <= z_reg;
                expected_reg[sel_idx] <= total_reg;
                received_reg[sel_idx] <= base_rx;
            end
            else
            begin
                received_reg[sel_idx] <= base_rx + clip_len;
            end
        end
        if (cmd.out_load)
        begin
            event_res <= cmd.out_kind;
            last      <= cmd.out_last;
            case (cmd.out_kind)
                frt_pkg::EV_DONE:
                begin
                    slot           <= frt_pkg::SLOT_OUT_W'(rd_idx);
                    event_id       <= ident_reg[rd_idx];
                    is_compressed  <= comp_bit_reg[rd_idx];
                    target_x       <= pos_x_reg[rd_idx];
                    target_y       <= pos_y_reg[rd_idx];
                    target_z       <= pos_z_reg[rd_idx];
                    payload_length <= clip_total;
                end
                frt_pkg::EV_TIMEOUT:
                begin
                    slot           <= frt_pkg::SLOT_OUT_W'(rd_idx);
                    event_id       <= ident_reg[rd_idx];
                    is_compressed  <= 1'b0;
                    target_x       <= '0;
                    target_y       <= '0;
                    target_z       <= '0;
                    payload_length <= '0;
                end
                default:
                begin
                    slot           <= '0;
                    event_id       <= id_reg;
                    is_compressed  <= 1'b0;
                    target_x       <= '0;
                    target_y       <= '0;
                    target_z       <= '0;
                    payload_length <= '0;
                end
            endcase
        end
    end

endmodule

/* rtl/core/frt_checker.sv */
module frt_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic [1:0]                         event_res,
    input logic [frt_pkg::SLOT_OUT_W-1:0]     slot,
    input logic [frt_pkg::ID_W-1:0]           event_id,
    input logic                               is_compressed,
    input logic signed [frt_pkg::COORD_W-1:0] target_x,
    input logic signed [frt_pkg::COORD_W-1:0] target_y,
    input logic signed [frt_pkg::COORD_W-1:0] target_z,
    input logic [frt_pkg::LEN_W-1:0]          payload_length,
    input logic                               last
);

    // A stalled event must hold until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_id) && $stable(event_res)
                                   && $stable(slot) && $stable(last))
        else $error("event changed while stalled");

    // Only completions carry flag, coordinates and length.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res != frt_pkg::EV_DONE) |->
            !is_compressed && (target_x == 0) && (target_y == 0) && (target_z == 0)
            && (payload_length == 0))
        else $error("non-completion event carries completion fields");

    // Dropped items report slot zero and end their item.
    a_drop_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((event_res == frt_pkg::EV_RANGE) || (event_res == frt_pkg::EV_FULL))
            |-> (slot == 0) && last)
        else $error("drop event with nonzero slot or without last");

    // A completion is the only event of its item and never exceeds the buffer.
    a_done_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == frt_pkg::EV_DONE) |->
            last && (payload_length <= frt_pkg::LEN_W'(frt_pkg::BUFFER_BYTES)))
        else $error("bad completion event");

endmodule

bind fragment_reassembly_tracker frt_checker u_frt_checker (.*);
